[sv/assert_macros.svh]
// Assertion macros shared by the downmix RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pcmdmx_pkg.sv]
// Shared types and constants for the PCM to stereo 16-bit downmix block.
// Used by every module of the block; depends on nothing.
package pcmdmx_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_POS_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = 4;
    localparam int FMT_W        = 3;
    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 19;
    localparam int WORD_W       = 32;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = CNT_W'(2);

    // Single-precision thresholds on the magnitude bits.
    localparam logic [30:0] F32_MAG_100 = 31'h42C8_0000;
    localparam logic [30:0] F32_MAG_ONE = 31'h3F80_0000;
    localparam logic [7:0]  F32_MIN_EXP = 8'd112;
    localparam logic [7:0]  F32_SHIFT_BASE = 8'd150;

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = -16'sd32768;

    typedef enum logic [FMT_W-1:0] {
        FMT_PCM8    = 3'd0,
        FMT_PCM16   = 3'd1,
        FMT_PCM24   = 3'd2,
        FMT_PCM32   = 3'd3,
        FMT_FLOAT32 = 3'd4
    } fmt_t;

    typedef enum logic {
        KIND_DIRECT,
        KIND_FLOAT
    } dec_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[sv/pcm_sample_to_stereo16_downmix_core.sv]
// Top level of the PCM to stereo 16-bit downmix block.
// Uses pcmdmx_pkg, pcmdmx_front, pcmdmx_sample_queue and pcmdmx_back.

// The block takes one raw little-endian sample word per transfer on the push
// side and returns one saturated stereo pair per completed frame on the pop
// side. It accepts one sample every cycle for as long as results are taken;
// a sample passes through the stage-one register into the sample queue and
// is mixed from the head of that queue; the result of the sample that closes
// a frame is registered into the result queue, where empty low shows it. The
// float path sets the depth of the front end: a first stage
// forms the exact product with 32767, a second rounds it to a 24-bit
// significand and shifts it down to an integer. A four-entry sample queue
// separates that decoder from the mixer, and a two-entry result queue lets
// new samples flow in while a finished frame waits to be popped.
// Channel 0 becomes left, channel 1 becomes right, and every further channel
// adds half its value, truncated toward zero, to both sides. A channel count
// of zero acts as mono and a count above eight acts as eight; with a mono
// stream right equals left. Configuration writes are always ready and take
// effect at once, so they should be made only while no frame is in flight.
// The channel position is not cleared by a configuration write: if the count
// is lowered mid-frame, the frame closes on the next sample.
module pcm_sample_to_stereo16_downmix_core (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   push,
    output logic                                   full,
    input  logic [pcmdmx_pkg::WORD_W-1:0]          sample_word,

    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] right_out,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pcmdmx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcmdmx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import pcmdmx_pkg::*;

    fmt_t                       format_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       cfg_write;

    q_status_t                  q_status;
    logic                       q_wr_en;
    logic signed [SAMPLE_W-1:0] q_wr_data;
    logic                       q_rd_en;
    logic signed [SAMPLE_W-1:0] q_rd_data;

    // The register file never stalls a write. Indexes beyond the two
    // registers are accepted and ignored.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            format_reg <= FMT_PCM16;
            count_reg  <= CHANNEL_COUNT_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SAMPLE_FORMAT: format_reg <= fmt_t'(cfg_wdata[FMT_W-1:0]);
                REG_CHANNEL_COUNT: count_reg  <= cfg_wdata[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Decoder: takes the sample transfer and turns the word into a 16-bit value.
    pcmdmx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .sample_word (sample_word),
        .format      (format_reg),
        .full        (full),
        .q_status    (q_status),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    // Decoupling queue between decoder and mixer.
    pcmdmx_sample_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // Mixer: frames the channels, saturates and holds finished results.
    pcmdmx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (count_reg),
        .q_status      (q_status),
        .q_rd_data     (q_rd_data),
        .q_rd_en       (q_rd_en),
        .empty         (empty),
        .pop           (pop),
        .left_out      (left_out),
        .right_out     (right_out)
    );

endmodule

[sv/pcmdmx_front.sv]
// Front end: accepts raw sample words and decodes them to signed 16-bit samples.
// Uses pcmdmx_pkg; feeds pcmdmx_sample_queue.
module pcmdmx_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [pcmdmx_pkg::WORD_W-1:0]        sample_word,
    input  pcmdmx_pkg::fmt_t                     format,
    output logic                                 full,
    input  pcmdmx_pkg::q_status_t                q_status,
    output logic                                 q_wr_en,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] q_wr_data
);
    import pcmdmx_pkg::*;

    logic                       accept;
    logic                       s1_move;
    logic [30:0]                mag;
    logic [7:0]                 expo;
    logic [23:0]                mant;
    logic signed [SAMPLE_W-1:0] direct_val;
    dec_kind_t                  kind;
    logic [38:0]                prod;
    logic [7:0]                 shift_full;

    logic                       s1_valid_reg, s1_valid_next;
    dec_kind_t                  s1_kind_reg;
    logic signed [SAMPLE_W-1:0] s1_direct_reg;
    logic [38:0]                s1_prod_reg;
    logic [5:0]                 s1_shift_reg;
    logic                       s1_neg_reg;

    logic [23:0]                rnd_q;
    logic                       rnd_half;
    logic                       rnd_sticky;
    logic                       rnd_up;
    logic [24:0]                rnd_sum;
    logic [39:0]                rnd_prod;
    logic [39:0]                rnd_shifted;
    logic [SAMPLE_W-1:0]        flt_mag;
    logic signed [SAMPLE_W-1:0] flt_val;

    assign s1_move = s1_valid_reg && !q_status.full;
    assign full    = s1_valid_reg && q_status.full;
    assign accept  = push && !full;

    // Stage one: integers and out-of-range floats finish here; others get their
    // exact product with 32767 (shift and subtract) and final shift amount.
    always_comb
    begin
        mag        = sample_word[30:0];
        expo       = mag[30:23];
        mant       = {1'b1, mag[22:0]};
        prod       = {mant, 15'b0} - {15'b0, mant};
        shift_full = F32_SHIFT_BASE - expo;
        kind       = KIND_DIRECT;
        case (format)
            FMT_PCM8:    direct_val = {sample_word[7:0] ^ 8'h80, 8'h00};
            FMT_PCM16:   direct_val = sample_word[15:0];
            FMT_PCM24:   direct_val = sample_word[23:8];
            FMT_PCM32:   direct_val = sample_word[31:16];
            FMT_FLOAT32:
            begin
                if (mag >= F32_MAG_100) begin
                    direct_val = '0;
                end else if (mag >= F32_MAG_ONE) begin
                    direct_val = sample_word[31] ? -S16_MAX : S16_MAX;
                end else begin
                    direct_val = '0;
                    if (expo >= F32_MIN_EXP) begin
                        kind = KIND_FLOAT;
                    end
                end
            end
            default:     direct_val = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_kind_reg   <= kind;
            s1_direct_reg <= direct_val;
            s1_prod_reg   <= prod;
            s1_shift_reg  <= shift_full[5:0];
            s1_neg_reg    <= sample_word[31];
        end
    end

    // Stage two: round the product to a 24-bit significand, ties to even,
    // then truncate to an integer and apply the sign.
    always_comb
    begin
        if (s1_prod_reg[38]) begin
            rnd_q      = s1_prod_reg[38:15];
            rnd_half   = s1_prod_reg[14];
            rnd_sticky = |s1_prod_reg[13:0];
        end else begin
            rnd_q      = s1_prod_reg[37:14];
            rnd_half   = s1_prod_reg[13];
            rnd_sticky = |s1_prod_reg[12:0];
        end
        rnd_up      = rnd_half && (rnd_sticky || rnd_q[0]);
        rnd_sum     = {1'b0, rnd_q} + 25'(rnd_up);
        rnd_prod    = s1_prod_reg[38] ? {rnd_sum, 15'b0} : {1'b0, rnd_sum, 14'b0};
        rnd_shifted = rnd_prod >> s1_shift_reg;
        flt_mag     = rnd_shifted[SAMPLE_W-1:0];
        flt_val     = s1_neg_reg ? -$signed(flt_mag) : $signed(flt_mag);
    end

    assign q_wr_en   = s1_move;
    assign q_wr_data = (s1_kind_reg == KIND_FLOAT) ? flt_val : s1_direct_reg;

endmodule

[sv/pcmdmx_sample_queue.sv]
// Short queue of decoded samples between the front end and the mixer.
// Uses pcmdmx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcmdmx_sample_queue (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic signed [pcmdmx_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                                   rd_en,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] rd_data,
    output pcmdmx_pkg::q_status_t                  status
);
    import pcmdmx_pkg::*;

    logic signed [SAMPLE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]            count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `ASSERT_IMPLIES(a_no_write_when_full, clk, rst_n, wr_en, !status.full,
        "sample queue written while full")
    `ASSERT_IMPLIES(a_no_read_when_empty, clk, rst_n, rd_en, !status.empty,
        "sample queue read while empty")

endmodule

[sv/pcmdmx_back.sv]
// Back end: counts channels, mixes samples into a stereo frame, queues results.
// Uses pcmdmx_pkg and assert_macros.svh; drains pcmdmx_sample_queue.
`include "assert_macros.svh"

module pcmdmx_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [pcmdmx_pkg::CNT_W-1:0]           channel_count,
    input  pcmdmx_pkg::q_status_t                  q_status,
    input  logic signed [pcmdmx_pkg::SAMPLE_W-1:0] q_rd_data,
    output logic                                   q_rd_en,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [pcmdmx_pkg::SAMPLE_W-1:0] right_out
);
    import pcmdmx_pkg::*;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > ACC_W'(S16_MAX)) begin
            r = S16_MAX;
        end else if (v < ACC_W'(S16_MIN)) begin
            r = S16_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    logic                       consume;
    logic [CNT_W-1:0]           cc_eff;
    logic [CNT_W:0]             pos_plus;
    logic                       complete;
    logic signed [ACC_W-1:0]    v_acc;
    logic signed [ACC_W-1:0]    v_bias;
    logic signed [ACC_W-1:0]    v_half;
    logic signed [ACC_W-1:0]    left_mix;
    logic signed [ACC_W-1:0]    right_mix;

    logic [CHAN_POS_W-1:0]      pos_reg, pos_next;
    logic signed [ACC_W-1:0]    left_acc_reg, left_acc_next;
    logic signed [ACC_W-1:0]    right_acc_reg, right_acc_next;

    logic signed [SAMPLE_W-1:0] out_left_reg [2];
    logic signed [SAMPLE_W-1:0] out_right_reg [2];
    logic                       out_wr_ptr_reg, out_rd_ptr_reg;
    logic [1:0]                 out_count_reg, out_count_next;
    logic                       out_wr;
    logic                       out_rd;

    assign out_rd  = pop && !empty;
    assign consume = !q_status.empty && (out_count_reg != 2'd2);
    assign q_rd_en = consume;
    assign out_wr  = consume && complete;

    always_comb
    begin
        if (channel_count == '0) begin
            cc_eff = CNT_W'(1);
        end else if (channel_count > CNT_W'(MAX_CHANNELS)) begin
            cc_eff = CNT_W'(MAX_CHANNELS);
        end else begin
            cc_eff = channel_count;
        end
        pos_plus = (CNT_W+1)'(pos_reg) + (CNT_W+1)'(1);
        complete = (pos_plus >= {1'b0, cc_eff});
    end

    // Half of a sample, truncated toward zero.
    always_comb
    begin
        v_acc  = ACC_W'(q_rd_data);
        v_bias = v_acc + $signed({{(ACC_W-1){1'b0}}, q_rd_data[SAMPLE_W-1]});
        v_half = v_bias >>> 1;
    end

    always_comb
    begin
        if (pos_reg == '0) begin
            left_mix  = v_acc;
            right_mix = '0;
        end else if (pos_reg == CHAN_POS_W'(1)) begin
            left_mix  = left_acc_reg;
            right_mix = v_acc;
        end else begin
            left_mix  = left_acc_reg + v_half;
            right_mix = right_acc_reg + v_half;
        end
        if (cc_eff == CNT_W'(1)) begin
            right_mix = left_mix;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        left_acc_next  = left_acc_reg;
        right_acc_next = right_acc_reg;
        if (consume) begin
            if (complete) begin
                pos_next       = '0;
                left_acc_next  = '0;
                right_acc_next = '0;
            end else begin
                pos_next       = pos_reg + CHAN_POS_W'(1);
                left_acc_next  = left_mix;
                right_acc_next = right_mix;
            end
        end
    end

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_wr && !out_rd) begin
            out_count_next = out_count_reg + 2'd1;
        end else if (out_rd && !out_wr) begin
            out_count_next = out_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= '0;
            left_acc_reg   <= '0;
            right_acc_reg  <= '0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_count_reg  <= '0;
        end else begin
            pos_reg        <= pos_next;
            left_acc_reg   <= left_acc_next;
            right_acc_reg  <= right_acc_next;
            out_count_reg  <= out_count_next;
            if (out_wr) begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (out_rd) begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr) begin
            out_left_reg[out_wr_ptr_reg]  <= sat16(left_mix);
            out_right_reg[out_wr_ptr_reg] <= sat16(right_mix);
        end
    end

    assign empty     = (out_count_reg == '0);
    assign left_out  = out_left_reg[out_rd_ptr_reg];
    assign right_out = out_right_reg[out_rd_ptr_reg];

    `ASSERT_IMPLIES(a_result_has_room, clk, rst_n, out_wr, out_count_reg != 2'd2,
        "result written with no free result slot")
    `ASSERT_NEXT(a_frame_restarts, clk, rst_n, out_wr, pos_reg == '0,
        "channel position not cleared after a completed frame")

endmodule
